// ===== rtl/gmv_pkg.sv =====
// ----------------------------------------------------------------------------
// gmv_pkg
// Shared widths, constants, types and the divider step for the grid mesh
// vertex index generator.
// ----------------------------------------------------------------------------
package gmv_pkg;

    localparam int CFG_W     = 11;          // cells_per_side and coordinates
    localparam int STR_W     = CFG_W + 1;   // row stride, N+1
    localparam int FRAC_BITS = 16;
    localparam int POS_W     = 17;          // unsigned Q1.16
    localparam int IDX_W     = 21;
    localparam int MASK_W    = 8;
    localparam int MAX_CELLS = 1024;
    localparam int N_RESET   = 64;

    // Pipeline: one entry stage plus the divider stages.
    localparam int NSTG      = 5;
    localparam int DIV_STEPS = FRAC_BITS / (NSTG - 1);  // quotient bits per stage

    localparam logic [POS_W-1:0] POS_ONE = POS_W'(1 << FRAC_BITS);

    typedef struct packed {
        logic [CFG_W-1:0]     rem;
        logic [FRAC_BITS-1:0] quo;
    } div_t;

    // Stage enables and the active cell count, top to divider
    typedef struct packed {
        logic [NSTG:1]    en;
        logic [CFG_W-1:0] n;
    } gmv_ctl_t;

    // DIV_STEPS restoring steps; remainder stays below n
    function automatic div_t div_step(div_t d_in, logic [CFG_W-1:0] n);
        div_t           d;
        logic [CFG_W:0] t;
        d = d_in;
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            t = {d.rem, 1'b0};
            if (t >= {1'b0, n})
            begin
                d.rem = CFG_W'(t - {1'b0, n});
                d.quo = {d.quo[FRAC_BITS-2:0], 1'b1};
            end
            else
            begin
                d.rem = t[CFG_W-1:0];
                d.quo = {d.quo[FRAC_BITS-2:0], 1'b0};
            end
        end
        return d;
    endfunction

endpackage

// ===== rtl/gmv_div.sv =====
// ----------------------------------------------------------------------------
// gmv_div
// Pipelined restoring divider: floor(coord * 2^FRAC_BITS / n), saturated to
// one when coord >= n.
// ----------------------------------------------------------------------------
module gmv_div (
    input  logic                     clk,
    input  gmv_pkg::gmv_ctl_t        ctl,
    input  logic [gmv_pkg::CFG_W-1:0] coord,
    output logic [gmv_pkg::POS_W-1:0] pos
);
    import gmv_pkg::*;

    div_t d_reg   [1:NSTG];
    logic sat_reg [1:NSTG];

    // entry stage: seed remainder with the coordinate
    always_ff @(posedge clk)
    begin
        if (ctl.en[1])
        begin
            sat_reg[1]   <= (coord >= ctl.n);
            d_reg[1].rem <= (coord >= ctl.n) ? '0 : coord;
            d_reg[1].quo <= '0;
        end
    end

    for (genvar k = 2; k <= NSTG; k++)
    begin : g_stage
        always_ff @(posedge clk)
        begin
            if (ctl.en[k])
            begin
                sat_reg[k] <= sat_reg[k-1];
                d_reg[k]   <= div_step(d_reg[k-1], ctl.n);
            end
        end
    end

    assign pos = sat_reg[NSTG] ? POS_ONE : POS_W'(d_reg[NSTG].quo);

endmodule

// ===== rtl/grid_mesh_vertex_index_generator.sv =====
// ----------------------------------------------------------------------------
// grid_mesh_vertex_index_generator
// Per-vertex position, border stitching mask and cell triangle indices for a
// square grid of N cells per side.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_*   : one-word write of cells_per_side (0 reads as 1, values above
//             the cell limit clamp). cfg_ready is always high; write only
//             while the pipe is empty.
//   vert_*  : one word per vertex (col, row); taken when vert_valid is high
//             and vert_stall low.
//   res_*   : one result word per vertex, in order; taken when res_valid is
//             high and res_stall low.
// One vertex per cycle while res_stall is low, through the entry and
// divider stages to res_valid. The depth is set by the 16-bit position
// divide, 4 quotient bits per stage over four stages, behind one entry
// stage holding the row*stride multiply and the border logic.
// Each stage moves when it is empty or the stage after it moves, so a stall
// on res backs up only as far as the pipe is full; bubbles are squeezed out
// and vert_stall rises only when every stage holds a word.
// Reset empties the pipe and loads cells_per_side with 64.
// ----------------------------------------------------------------------------
module grid_mesh_vertex_index_generator (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [gmv_pkg::CFG_W-1:0]  cfg_data,
    input  logic                       vert_valid,
    output logic                       vert_stall,
    input  logic [gmv_pkg::CFG_W-1:0]  col,
    input  logic [gmv_pkg::CFG_W-1:0]  row,
    output logic                       res_valid,
    input  logic                       res_stall,
    output logic [gmv_pkg::POS_W-1:0]  pos_x,
    output logic [gmv_pkg::POS_W-1:0]  pos_y,
    output logic [gmv_pkg::MASK_W-1:0] border_mask,
    output logic                       has_cell,
    output logic [gmv_pkg::IDX_W-1:0]  tri_a0,
    output logic [gmv_pkg::IDX_W-1:0]  tri_a1,
    output logic [gmv_pkg::IDX_W-1:0]  tri_a2,
    output logic [gmv_pkg::IDX_W-1:0]  tri_b0,
    output logic [gmv_pkg::IDX_W-1:0]  tri_b1,
    output logic [gmv_pkg::IDX_W-1:0]  tri_b2
);
    import gmv_pkg::*;

    // ---------------- configuration ----------------
    logic [CFG_W-1:0] n_reg, n_next;
    logic [STR_W-1:0] stride_reg, stride_next;

    assign cfg_ready = 1'b1;

    // clamp to 1..MAX_CELLS
    always_comb
    begin
        if (cfg_data == '0)
            n_next = CFG_W'(1);
        else if (32'(cfg_data) > MAX_CELLS)
            n_next = CFG_W'(MAX_CELLS);
        else
            n_next = cfg_data;
        stride_next = {1'b0, n_next} + STR_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg      <= CFG_W'(N_RESET);
            stride_reg <= STR_W'(N_RESET + 1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            n_reg      <= n_next;
            stride_reg <= stride_next;
        end
    end

    // ---------------- pipeline flow control ----------------
    logic [NSTG:1]   vld_reg;
    logic [NSTG+1:1] en;

    always_comb
    begin
        en[NSTG+1] = !res_stall;
        for (int k = NSTG; k >= 1; k--)
            en[k] = !vld_reg[k] || en[k+1];
    end

    assign vert_stall = !en[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (en[1])
                vld_reg[1] <= vert_valid;
            for (int k = 2; k <= NSTG; k++)
                if (en[k])
                    vld_reg[k] <= vld_reg[k-1];
        end
    end

    // ---------------- entry stage logic ----------------
    logic                    in_grid, row_inner, col_inner, cell_next;
    logic [MASK_W-1:0]       mask_next;
    logic [CFG_W+STR_W-1:0]  prod_full;

    always_comb
    begin
        in_grid   = (col <= n_reg) && (row <= n_reg);
        row_inner = (row != '0) && (row != n_reg);
        col_inner = (col != '0) && (col != n_reg);
        cell_next = (col < n_reg) && (row < n_reg);
        mask_next = '0;
        if (in_grid)
        begin
            // pair bits: coordinate odd, coordinate mod 4 in {2,3}
            if (col == '0 && row_inner)   mask_next[1:0] = row[1:0];
            if (col == n_reg && row_inner) mask_next[3:2] = row[1:0];
            if (row == '0 && col_inner)   mask_next[5:4] = col[1:0];
            if (row == n_reg && col_inner) mask_next[7:6] = col[1:0];
        end
    end

    assign prod_full = row * stride_reg;

    // ---------------- index and side-band pipeline ----------------
    logic [MASK_W-1:0] mask_reg [1:NSTG];
    logic              cell_reg [1:NSTG];
    logic [CFG_W-1:0]  s1_col_reg;
    logic [IDX_W-1:0]  s1_prod_reg;
    logic [IDX_W-1:0]  a0_reg [2:NSTG];   // (c, r)
    logic [IDX_W-1:0]  a1_reg [3:NSTG];   // (c, r+1)
    logic [IDX_W-1:0]  a2_reg [3:NSTG];   // (c+1, r)
    logic [IDX_W-1:0]  b2_reg [4:NSTG];   // (c+1, r+1)

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            mask_reg[1]  <= mask_next;
            cell_reg[1]  <= cell_next;
            s1_col_reg   <= col;
            s1_prod_reg  <= prod_full[IDX_W-1:0];
        end
        for (int k = 2; k <= NSTG; k++)
        begin
            if (en[k])
            begin
                mask_reg[k] <= mask_reg[k-1];
                cell_reg[k] <= cell_reg[k-1];
            end
        end
        if (en[2])
            a0_reg[2] <= s1_prod_reg + IDX_W'(s1_col_reg);
        if (en[3])
        begin
            a0_reg[3] <= a0_reg[2];
            a1_reg[3] <= a0_reg[2] + IDX_W'(stride_reg);
            a2_reg[3] <= a0_reg[2] + IDX_W'(1);
        end
        if (en[4])
        begin
            a0_reg[4] <= a0_reg[3];
            a1_reg[4] <= a1_reg[3];
            a2_reg[4] <= a2_reg[3];
            b2_reg[4] <= a1_reg[3] + IDX_W'(1);
        end
        if (en[5])
        begin
            a0_reg[5] <= a0_reg[4];
            a1_reg[5] <= a1_reg[4];
            a2_reg[5] <= a2_reg[4];
            b2_reg[5] <= b2_reg[4];
        end
    end

    // ---------------- position dividers ----------------
    gmv_ctl_t div_ctl;

    assign div_ctl.en = en[NSTG:1];
    assign div_ctl.n  = n_reg;

    gmv_div u_div_x (
        .clk   (clk),
        .ctl   (div_ctl),
        .coord (col),
        .pos   (pos_x)
    );

    gmv_div u_div_y (
        .clk   (clk),
        .ctl   (div_ctl),
        .coord (row),
        .pos   (pos_y)
    );

    // ---------------- result word ----------------
    assign res_valid   = vld_reg[NSTG];
    assign border_mask = mask_reg[NSTG];
    assign has_cell    = cell_reg[NSTG];
    assign tri_a0      = has_cell ? a0_reg[NSTG] : '0;
    assign tri_a1      = has_cell ? a1_reg[NSTG] : '0;
    assign tri_a2      = has_cell ? a2_reg[NSTG] : '0;
    assign tri_b0      = has_cell ? a2_reg[NSTG] : '0;
    assign tri_b1      = has_cell ? a1_reg[NSTG] : '0;
    assign tri_b2      = has_cell ? b2_reg[NSTG] : '0;

`ifndef SYNTHESIS
    // a cell vertex has col and row below n, so its position is below one
    a_cell_pos: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && has_cell |-> !pos_x[FRAC_BITS] && !pos_y[FRAC_BITS])
        else $error("cell vertex with saturated position");

    // upper row of the cell is one stride above the lower row
    a_stride: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && has_cell |-> tri_a1 == IDX_W'(tri_a0 + IDX_W'(stride_reg)))
        else $error("triangle rows not one stride apart");

    a_corner: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && has_cell |-> tri_b2 == IDX_W'(tri_a1 + IDX_W'(1)))
        else $error("far corner index mismatch");

    // corners carry no stitching: side and bottom/top pairs never mix
    a_mask: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !((border_mask[3:0] != '0) && (border_mask[7:4] != '0)))
        else $error("stitch bits on two crossing edges");

    // input backs up only when the entry stage holds a word
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        vert_stall |-> vld_reg[1] && res_valid)
        else $error("input stalled with room in the pipe");
`endif

endmodule
